// ===== src/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Types and constants shared by the tick task scheduler table modules.
// ----------------------------------------------------------------------------
package tts_pkg;

    // Most results that one dispatch item may give
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Operation codes
    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_TICK     = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_REMOVE   = 2'd3
    } t_opcode;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_NONE       = 3'd3,
        ST_BAD_HANDLE = 3'd4
    } t_status;

    // Input item
    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  task_handle;
        logic [15:0] start_delay;
        logic [15:0] repeat_period;
        logic [3:0]  slot_index;
    } t_in_item;

    // Result item
    typedef struct packed {
        t_status    status;
        logic [3:0] slot;
        logic [7:0] ready_handle;
        logic       freed_one_shot;
        logic       last;
    } t_out_item;

    // One stored slot entry
    typedef struct packed {
        logic [7:0]  handle;
        logic [15:0] delay;
        logic [15:0] period;
    } t_slot_entry;

    // Flags and result of the shared count unit
    typedef struct packed {
        logic [15:0] result;
        logic        a_zero;
    } t_alu_res;

    function automatic t_out_item mk_out(t_status st, logic [3:0] sl, logic [7:0] h,
                                         logic freed, logic lst);
        t_out_item o;
        o.status         = st;
        o.slot           = sl;
        o.ready_handle   = h;
        o.freed_one_shot = freed;
        o.last           = lst;
        return o;
    endfunction

endpackage

// ===== src/tts_slot_mem.sv =====
// ----------------------------------------------------------------------------
// tts_slot_mem
// Slot entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tts_slot_mem #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  tts_pkg::t_slot_entry       i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output tts_pkg::t_slot_entry       o_rdata
);

    tts_pkg::t_slot_entry r_mem [DEPTH];
    tts_pkg::t_slot_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tts_slot_alu.sv =====
// ----------------------------------------------------------------------------
// tts_slot_alu
// Shared count unit: result is b when a is zero, else a minus one.
// Serves delay countdown with reload, period store and one-shot check.
// ----------------------------------------------------------------------------
module tts_slot_alu (
    input  logic [15:0]       i_a,
    input  logic [15:0]       i_b,
    output tts_pkg::t_alu_res o_res
);

    logic a_zero;

    assign a_zero       = (i_a == 16'd0);
    assign o_res.a_zero = a_zero;
    assign o_res.result = a_zero ? i_b : (i_a - 16'd1);

endmodule

// ===== src/tick_task_scheduler_table_core.sv =====
// ----------------------------------------------------------------------------
// tick_task_scheduler_table_core
// Task slot table with register, tick, dispatch and remove operations,
// walked one slot at a time by a small sequencer around a shared count unit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall| o_out_item (t_out_item)
//
//  Register scans upward for the lowest free slot (all slots when full);
//  remove needs no walk. Tick walks every slot; dispatch walks up to the
//  last flagged slot or the result limit. Each occupied (tick) or flagged
//  (dispatch) slot is read, then updated, as the slot store has one read port.
//  Reset clears state, index, result count, output valid and the occupied and run flags; the store needs no clearing.
//  A stalled output holds the walk at the next result; input is taken only idle.
// ----------------------------------------------------------------------------
module tick_task_scheduler_table_core #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tts_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tts_pkg::t_out_item  o_out_item
);

    localparam int IDX_W = $clog2(TASK_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EXEC = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [tts_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    tts_pkg::t_in_item          r_item, n_item;
    logic [TASK_SLOTS-1:0]      r_used, n_used;
    logic [TASK_SLOTS-1:0]      r_ready, n_ready;
    logic                       r_out_valid, n_out_valid;
    tts_pkg::t_out_item         r_out, n_out;
    tts_pkg::t_out_item         r_fin, n_fin;

    // store and count unit hookup
    logic                       mem_we, mem_re;
    logic [IDX_W-1:0]           mem_waddr;
    tts_pkg::t_slot_entry       mem_wdata, mem_rdata;
    logic [15:0]                alu_a, alu_b;
    tts_pkg::t_alu_res          alu_res;

    logic                       out_free;
    logic                       last_idx;
    logic [IDX_W+3:0]           idx_wide;
    logic [3:0]                 idx_slot;
    logic [TASK_SLOTS-1:0]      above;
    logic                       more_ready;
    logic [IDX_W-1:0]           rm_idx;
    logic                       rm_in_range;
    logic                       res_last;

    tts_slot_mem #(
        .DEPTH (TASK_SLOTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    tts_slot_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // walk helpers
    assign out_free    = !r_out_valid || !i_out_stall;
    assign last_idx    = (r_idx == IDX_W'(TASK_SLOTS - 1));
    assign idx_wide    = {4'b0000, r_idx};
    assign idx_slot    = idx_wide[3:0];
    assign above       = ({TASK_SLOTS{1'b1}} << r_idx) << 1;
    assign more_ready  = |(r_ready & above);
    assign rm_idx      = IDX_W'(i_in_item.slot_index);
    assign rm_in_range = (32'(i_in_item.slot_index) < TASK_SLOTS);
    assign res_last    = last_idx || !more_ready
                         || (r_cnt == tts_pkg::CNT_W'(tts_pkg::MAX_RESULTS - 1));

    // count unit operand select
    always_comb begin
        alu_a = r_item.repeat_period;
        alu_b = 16'd0;
        if (r_state == S_EXEC) begin
            if (r_item.opcode == tts_pkg::OP_TICK) begin
                alu_a = mem_rdata.delay;
                alu_b = mem_rdata.period;
            end else begin
                alu_a = mem_rdata.period;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_item      = r_item;
        n_used      = r_used;
        n_ready     = r_ready;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_fin       = r_fin;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = mem_rdata;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    n_idx  = '0;
                    n_cnt  = '0;
                    case (i_in_item.opcode)
                        tts_pkg::OP_REGISTER: begin
                            if (i_in_item.task_handle == 8'd0) begin
                                n_fin   = tts_pkg::mk_out(tts_pkg::ST_BAD_HANDLE, 4'd0,
                                                          8'd0, 1'b0, 1'b1);
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        tts_pkg::OP_REMOVE: begin
                            n_fin = tts_pkg::mk_out(tts_pkg::ST_EMPTY,
                                                    i_in_item.slot_index,
                                                    8'd0, 1'b0, 1'b1);
                            if (rm_in_range) begin
                                if (r_used[rm_idx]) begin
                                    n_fin.status = tts_pkg::ST_OK;
                                end
                                n_used[rm_idx]  = 1'b0;
                                n_ready[rm_idx] = 1'b0;
                            end
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                case (r_item.opcode)
                    tts_pkg::OP_REGISTER: begin
                        if (!r_used[r_idx]) begin
                            // claim the lowest free slot
                            mem_we           = 1'b1;
                            mem_wdata.handle = r_item.task_handle;
                            mem_wdata.delay  = r_item.start_delay;
                            mem_wdata.period = alu_res.result;
                            n_used[r_idx]    = 1'b1;
                            n_ready[r_idx]   = 1'b0;
                            n_fin   = tts_pkg::mk_out(tts_pkg::ST_OK, idx_slot,
                                                      8'd0, 1'b0, 1'b1);
                            n_state = S_EMIT;
                        end else if (last_idx) begin
                            n_fin   = tts_pkg::mk_out(tts_pkg::ST_FULL, 4'd0,
                                                      8'd0, 1'b0, 1'b1);
                            n_state = S_EMIT;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    tts_pkg::OP_TICK: begin
                        if (r_used[r_idx]) begin
                            mem_re  = 1'b1;
                            n_state = S_EXEC;
                        end else if (last_idx) begin
                            n_fin   = tts_pkg::mk_out(tts_pkg::ST_OK, 4'd0,
                                                      8'd0, 1'b0, 1'b1);
                            n_state = S_EMIT;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    default: begin
                        // dispatch: find the next flagged slot
                        if (r_ready[r_idx]) begin
                            mem_re  = 1'b1;
                            n_state = S_EXEC;
                        end else if (last_idx) begin
                            n_fin   = tts_pkg::mk_out(tts_pkg::ST_NONE, 4'd0,
                                                      8'd0, 1'b0, 1'b1);
                            n_state = S_EMIT;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                endcase
            end

            S_EXEC: begin
                if (r_item.opcode == tts_pkg::OP_TICK) begin
                    // count down, flag and reload when due
                    mem_we          = 1'b1;
                    mem_wdata.delay = alu_res.result;
                    if (alu_res.a_zero) begin
                        n_ready[r_idx] = 1'b1;
                    end
                    if (last_idx) begin
                        n_fin   = tts_pkg::mk_out(tts_pkg::ST_OK, 4'd0,
                                                  8'd0, 1'b0, 1'b1);
                        n_state = S_EMIT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SCAN;
                    end
                end else if (out_free) begin
                    // dispatch one flagged slot
                    n_out_valid    = 1'b1;
                    n_out          = tts_pkg::mk_out(tts_pkg::ST_OK, idx_slot,
                                                     mem_rdata.handle, alu_res.a_zero,
                                                     res_last);
                    n_ready[r_idx] = 1'b0;
                    if (alu_res.a_zero) begin
                        n_used[r_idx] = 1'b0;
                    end
                    n_cnt = r_cnt + 1'b1;
                    if (res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_fin;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_used      <= '0;
            r_ready     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_used      <= n_used;
            r_ready     <= n_ready;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
        r_fin  <= n_fin;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
